// ----- rtl/core/bffa_pkg.sv -----
// bffa_pkg: shared constants, field widths, status/opcode codes and fsm states
// for the bitmap first-fit allocator
// no dependencies

package bffa_pkg;

	// default geometry of the used/free map
	localparam int unsigned CAPACITY_DEF  = 4096;
	localparam int unsigned WORD_BITS_DEF = 64;

	// fixed field widths
	localparam int unsigned IDX_W    = 12;
	localparam int unsigned COUNT_W  = 13;
	localparam int unsigned STATUS_W = 2;

	localparam logic [COUNT_W-1:0] COUNT_RST = 13'd4096;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_NOSPACE = 2'd1,
		ST_INVALID = 2'd2
	} status_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SPLIT,
		S_PREP,
		S_SCAN,
		S_DONE
	} state_t;

endpackage

// ----- rtl/core/bffa_ifs.sv -----
// bffa channel interfaces: request, response and count configuration
// each carries valid/ready and its payload; depends on bffa_pkg

interface bffa_req_if;
	logic                          valid;
	logic                          ready;
	bffa_pkg::opcode_t             opcode;
	logic [bffa_pkg::IDX_W-1:0]    start_index;
	logic [bffa_pkg::IDX_W-1:0]    free_index;

	modport source (output valid, opcode, start_index, free_index, input ready);
	modport sink   (input valid, opcode, start_index, free_index, output ready);
endinterface

interface bffa_rsp_if;
	logic                          valid;
	logic                          ready;
	bffa_pkg::status_t             status;
	logic [bffa_pkg::IDX_W-1:0]    cluster_index;

	modport source (output valid, status, cluster_index, input ready);
	modport sink   (input valid, status, cluster_index, output ready);
endinterface

interface bffa_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [bffa_pkg::COUNT_W-1:0]  cluster_count;

	modport source (output valid, cluster_count, input ready);
	modport sink   (input valid, cluster_count, output ready);
endinterface

// ----- rtl/core/bitmap_first_fit_allocator.sv -----
// bitmap_first_fit_allocator: first-fit cluster allocator over a used/free bitmap
// held in one synchronous memory; depends on bffa_pkg and the bffa_ifs interfaces

// The block keeps one used bit per cluster in a memory of CAPACITY/WORD_BITS words
// (64 words of 64 bits by default). CAPACITY is fixed by the 12-bit cluster index
// fields. After reset it runs a clearing pass of one word a cycle and takes no
// request until that pass is done; the count register can be written at any time.
// An allocate reads the word holding the start hint, then one word per cycle upward,
// and marks the lowest free cluster at or above the hint and below the live count
// (the count register, capped at CAPACITY). Its result passes the split, prep, scan
// and done states and then the output register; the scan rate is set by the single
// memory read port. A free does one read and one write of the modified word. A hint
// or free index at or beyond the live count touches no memory and skips the scan
// state. Requests are handled one at a time; the next request is taken in the cycle
// after a result is loaded into the output register, and a result waits there while
// the next request is taken.

module bitmap_first_fit_allocator #(
	parameter int unsigned WORD_BITS = bffa_pkg::WORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	bffa_cfg_if.sink    cfg,
	bffa_req_if.sink    req,
	bffa_rsp_if.source  rsp
);

	// map size follows the width of the cluster index fields
	localparam int unsigned CAPACITY  = bffa_pkg::CAPACITY_DEF;
	localparam int unsigned IDX_W     = bffa_pkg::IDX_W;
	localparam int unsigned MAP_WORDS = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
	localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int unsigned BW        = $clog2(WORD_BITS);
	localparam int unsigned LIM_W     = $clog2(CAPACITY + 1);
	// one spare bit so that base + WORD_BITS never wraps
	localparam int unsigned CNT_W     =
		((LIM_W > bffa_pkg::COUNT_W) ? LIM_W : bffa_pkg::COUNT_W) + 1;
	// reciprocal for index / WORD_BITS, exact for every IDX_W-bit index
	localparam int unsigned SH        = IDX_W + BW;
	localparam int unsigned RCP_W     = SH + 1;
	localparam int unsigned RECIP     = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;
	localparam int unsigned PROD_W    = IDX_W + RCP_W;

	// control state
	bffa_pkg::state_t              state_q, state_d;
	logic [AW-1:0]                 clr_q;
	logic [bffa_pkg::COUNT_W-1:0]  count_q;
	logic                          rsp_valid_q;

	// request context
	bffa_pkg::opcode_t             op_q;
	logic [IDX_W-1:0]              idx_q;
	logic [AW-1:0]                 word_q;
	logic [BW-1:0]                 bit_q;      // lowest bit allowed in the current word
	logic [CNT_W-1:0]              base_q;     // cluster index of bit 0 of word_q
	bffa_pkg::status_t             res_status_q;
	logic [IDX_W-1:0]              res_index_q;

	// output register
	bffa_pkg::status_t             rsp_status_q;
	logic [IDX_W-1:0]              rsp_index_q;

	// bitmap memory
	logic [WORD_BITS-1:0]          map_mem [MAP_WORDS];
	logic [WORD_BITS-1:0]          rdata_q;

	// memory port controls
	logic                          rd_en, wr_en;
	logic [AW-1:0]                 rd_addr, wr_addr;
	logic [WORD_BITS-1:0]          wr_data;

	// finish / advance strobes
	logic                          fin, adv;
	bffa_pkg::status_t             fin_status;
	logic [IDX_W-1:0]              fin_index;

	// datapath
	logic [CNT_W-1:0]              limit;
	logic [PROD_W-1:0]             prod;
	logic [IDX_W-1:0]              quot;
	logic [CNT_W-1:0]              base_calc;
	logic [BW-1:0]                 bit_calc;
	logic [CNT_W-1:0]              rem;
	logic [CNT_W-1:0]              next_base;
	logic [WORD_BITS-1:0]          cand;
	logic [WORD_BITS-1:0]          low_sel;
	logic [WORD_BITS-1:0]          clr_mask;
	logic [BW-1:0]                 pos;
	logic                          found;
	logic                          out_free;

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == bffa_pkg::S_IDLE);

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.cluster_index = rsp_index_q;

	assign out_free = !rsp_valid_q || rsp.ready;

	// live count saturates at capacity
	assign limit = (CNT_W'(count_q) > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY)
	                                                    : CNT_W'(count_q);

	// word number of the hint: multiply by reciprocal, shift
	assign prod = PROD_W'(idx_q) * PROD_W'(RECIP);
	assign quot = IDX_W'(prod >> SH);

	// bit offset of the hint inside its word
	assign base_calc = CNT_W'(word_q) * CNT_W'(WORD_BITS);
	assign bit_calc  = BW'(CNT_W'(idx_q) - base_calc);

	assign rem       = limit - base_q;
	assign next_base = base_q + CNT_W'(WORD_BITS);
	assign clr_mask  = WORD_BITS'(1) << bit_q;

	// candidates: free bits at or above the hint bit and below the live count
	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			cand[j] = !rdata_q[j] && (BW'(j) >= bit_q) && (CNT_W'(j) < rem);
		end
	end

	// lowest candidate, as one-hot and as bit position
	assign low_sel = cand & ~(cand - WORD_BITS'(1));
	assign found   = |cand;

	always_comb begin
		pos = '0;
		for (int j = WORD_BITS - 1; j >= 0; j--) begin
			if (cand[j]) begin
				pos = BW'(j);
			end
		end
	end

	// sequencer: next state and memory port controls
	always_comb begin
		state_d    = state_q;
		rd_en      = 1'b0;
		rd_addr    = word_q;
		wr_en      = 1'b0;
		wr_addr    = word_q;
		wr_data    = '0;
		fin        = 1'b0;
		fin_status = bffa_pkg::ST_OK;
		fin_index  = '0;
		adv        = 1'b0;
		unique case (state_q)
			bffa_pkg::S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				if (clr_q == AW'(MAP_WORDS - 1)) begin
					state_d = bffa_pkg::S_IDLE;
				end
			end
			bffa_pkg::S_IDLE: begin
				if (req.valid) begin
					state_d = bffa_pkg::S_SPLIT;
				end
			end
			bffa_pkg::S_SPLIT: begin
				state_d = bffa_pkg::S_PREP;
			end
			bffa_pkg::S_PREP: begin
				// hint or free index outside the live range: nothing to touch
				if (CNT_W'(idx_q) >= limit) begin
					fin        = 1'b1;
					fin_status = (op_q == bffa_pkg::OP_FREE) ? bffa_pkg::ST_INVALID
					                                         : bffa_pkg::ST_NOSPACE;
					state_d    = bffa_pkg::S_DONE;
				end else begin
					rd_en   = 1'b1;
					state_d = bffa_pkg::S_SCAN;
				end
			end
			bffa_pkg::S_SCAN: begin
				if (op_q == bffa_pkg::OP_FREE) begin
					wr_en   = 1'b1;
					wr_data = rdata_q & ~clr_mask;
					fin     = 1'b1;
					state_d = bffa_pkg::S_DONE;
				end else if (found) begin
					wr_en     = 1'b1;
					wr_data   = rdata_q | low_sel;
					fin       = 1'b1;
					fin_index = IDX_W'(base_q + CNT_W'(pos));
					state_d   = bffa_pkg::S_DONE;
				end else if (next_base >= limit) begin
					fin        = 1'b1;
					fin_status = bffa_pkg::ST_NOSPACE;
					state_d    = bffa_pkg::S_DONE;
				end else begin
					// move on to the next word
					adv     = 1'b1;
					rd_en   = 1'b1;
					rd_addr = word_q + AW'(1);
				end
			end
			bffa_pkg::S_DONE: begin
				if (out_free) begin
					state_d = bffa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bffa_pkg::S_CLEAR;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bffa_pkg::S_CLEAR;
			clr_q       <= '0;
			count_q     <= bffa_pkg::COUNT_RST;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == bffa_pkg::S_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cfg.valid) begin
				count_q <= cfg.cluster_count;
			end
			if (state_q == bffa_pkg::S_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// request context and result registers
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q  <= req.opcode;
			idx_q <= (req.opcode == bffa_pkg::OP_FREE) ? req.free_index : req.start_index;
		end
		if (state_q == bffa_pkg::S_SPLIT) begin
			word_q <= AW'(quot);
		end
		if (state_q == bffa_pkg::S_PREP) begin
			base_q <= base_calc;
			bit_q  <= bit_calc;
		end
		if (adv) begin
			word_q <= word_q + AW'(1);
			base_q <= next_base;
			bit_q  <= '0;
		end
		if (fin) begin
			res_status_q <= fin_status;
			res_index_q  <= fin_index;
		end
		if (state_q == bffa_pkg::S_DONE && out_free) begin
			rsp_status_q <= res_status_q;
			rsp_index_q  <= res_index_q;
		end
	end

	// bitmap memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= map_mem[rd_addr];
		end
	end

endmodule

// ----- rtl/core/bffa_checker.sv -----
// bffa_checker: port-level assertions for bitmap_first_fit_allocator
// bound to the top level; depends on bffa_pkg

module bffa_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input bffa_pkg::status_t           rsp_status,
	input logic [bffa_pkg::IDX_W-1:0]  rsp_index
);

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_index))
		else $error("stalled result changed or dropped");

	// one request in flight: no new transfer right after one
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in work");

	// every failed allocate or free reports index zero
	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != bffa_pkg::ST_OK |-> rsp_index == '0)
		else $error("nonzero index on failed result");

	// a result never appears in the cycle after a request transfer
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !$rose(rsp_valid))
		else $error("result faster than memory access allows");

endmodule

bind bitmap_first_fit_allocator bffa_checker u_bffa_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_index  (rsp.cluster_index)
);
